// ----- hw/rtl/dasp_pkg.sv -----
// ----------------------------------------------------------------------------
// dasp_pkg
// Types, codes and the grouped-code table shared by the AVP parser files.
// ----------------------------------------------------------------------------
package dasp_pkg;

   localparam int          MAX_DEPTH_DEFAULT      = 8;
   localparam logic [31:0] DEFAULT_VENDOR_RESET   = 32'd10415;
   localparam logic [23:0] HEADER_BYTES           = 24'd20;
   localparam int          QUEUE_DEPTH            = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] code;
      logic [7:0]  flags;
      logic [31:0] vendor_or_app;
      logic [31:0] hop_by_hop;
      logic [31:0] end_to_end;
      logic [23:0] data_length;
      logic [23:0] data_offset;
      logic [3:0]  depth;
      logic [2:0]  error_code;
      logic        last;
   } rsp_type;

   // record kinds
   localparam logic [2:0] KIND_HEADER    = 3'd0;
   localparam logic [2:0] KIND_BASIC     = 3'd1;
   localparam logic [2:0] KIND_GROUPED   = 3'd2;
   localparam logic [2:0] KIND_GROUP_SET = 3'd3;
   localparam logic [2:0] KIND_OK        = 3'd4;
   localparam logic [2:0] KIND_ERROR     = 3'd5;

   // error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_SHORT     = 3'd1;
   localparam logic [2:0] ERR_MISMATCH  = 3'd2;
   localparam logic [2:0] ERR_HDR_OVER  = 3'd3;
   localparam logic [2:0] ERR_PAD_OVER  = 3'd4;
   localparam logic [2:0] ERR_TOO_SMALL = 3'd5;
   localparam logic [2:0] ERR_TOO_DEEP  = 3'd6;

   // register indexes
   localparam logic REG_DEFAULT_VENDOR = 1'b0;

   typedef enum logic [2:0] {
      PH_HDR    = 3'd0,
      PH_CODE   = 3'd1,
      PH_LEN    = 3'd2,
      PH_VENDOR = 3'd3,
      PH_SKIP   = 3'd4
   } phase_type;

   // grouped code lookup, first match wins
   function automatic logic [2:0] avp_kind(input logic [31:0] code);
      logic [2:0] k;
      case (code)
         32'd440, 32'd431, 32'd446, 32'd443, 32'd456, 32'd1249: k = KIND_GROUP_SET;
         32'd437, 32'd873, 32'd876, 32'd823, 32'd833, 32'd413, 32'd458,
         32'd430, 32'd874, 32'd865, 32'd2000, 32'd2026, 32'd877, 32'd886,
         32'd1201, 32'd1213, 32'd2027: k = KIND_GROUPED;
         default: k = KIND_BASIC;
      endcase
      return k;
   endfunction

endpackage

// ----- hw/rtl/diameter_avp_stream_parser_unit.sv -----
// ----------------------------------------------------------------------------
// diameter_avp_stream_parser_unit
// Streaming Diameter parser: one message byte per item, header and AVP
// records out.
//
//   channel  direction  payload    handshake
//   req      in         req_type   req_valid / req_stall
//   rsp      out        rsp_type   rsp_valid / rsp_stall
//   csr      in/out     32-bit     APB write/read, pready tied high
//
// One byte per cycle while req_stall is low; the classifier is combinational.
// A byte yields at most two records, drained one per cycle while rsp_stall
// is low, through a four-entry queue and the output register; req_stall
// rises when fewer than two queue slots are free. Reset is synchronous and
// clears control state; the group stack needs no clearing.
// ----------------------------------------------------------------------------
module diameter_avp_stream_parser_unit #(
   parameter int MAX_DEPTH = dasp_pkg::MAX_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dasp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dasp_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import dasp_pkg::*;

   logic [31:0] vendor_ff;
   logic        take, nearly_full, q_nonempty, q_pop;
   logic [1:0]  rec_count;
   rsp_type     rec0, rec1, q_head;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_DEFAULT_VENDOR) ? vendor_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) vendor_ff <= DEFAULT_VENDOR_RESET;
      else if (csr_psel && csr_penable && csr_pwrite &&
               csr_paddr[2] == REG_DEFAULT_VENDOR)
         vendor_ff <= csr_pwdata;
   end

   assign req_stall = nearly_full;
   assign take      = req_valid && !nearly_full;

   dasp_front #(.MAX_DEPTH(MAX_DEPTH)) u_front (
      .clock          (clock),
      .reset          (reset),
      .take           (take),
      .item           (req_data),
      .default_vendor (vendor_ff),
      .rec_count      (rec_count),
      .rec0           (rec0),
      .rec1           (rec1)
   );

   dasp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_count  (rec_count),
      .push0       (rec0),
      .push1       (rec1),
      .pop         (q_pop),
      .nonempty    (q_nonempty),
      .nearly_full (nearly_full),
      .head        (q_head)
   );

   dasp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_nonempty (q_nonempty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- hw/rtl/dasp_front.sv -----
// ----------------------------------------------------------------------------
// dasp_front
// Byte classifier: header assembly, AVP walk, group stack; up to two
// records per byte.
// ----------------------------------------------------------------------------
module dasp_front #(
   parameter int MAX_DEPTH = dasp_pkg::MAX_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  dasp_pkg::req_type item,
   input  logic [31:0]       default_vendor,
   output logic [1:0]        rec_count,
   output dasp_pkg::rsp_type rec0,
   output dasp_pkg::rsp_type rec1
);
   import dasp_pkg::*;

   localparam int DW = $clog2(MAX_DEPTH + 1);
   localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   phase_type   phase_ff, phase_in;
   logic [23:0] offset_ff, offset_in;
   logic [23:0] msglen_ff, msglen_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] code_ff, code_in;
   logic [7:0]  flags_ff, flags_in;
   logic [31:0] vendor_ff, vendor_in;
   logic [31:0] hbh_ff, hbh_in;
   logic [23:0] avplen_ff, avplen_in;
   logic [23:0] pend_ff, pend_in;
   logic [23:0] stack_ff [MAX_DEPTH];
   logic [23:0] stack_in [MAX_DEPTH];
   logic [DW-1:0] depth_ff, depth_in;
   logic        errl_ff, errl_in;

   always_comb begin
      logic [7:0]  b;
      logic        eom;
      logic [23:0] off, o, len, dlen, next, pend_use;
      logic [31:0] sh;
      logic [25:0] pend;
      logic [DW-1:0] pd;
      logic [23:0] scope_pop, scope_cur;
      logic [2:0]  err, kd;
      logic        fin, vend, ok;
      logic [31:0] fin_vendor;
      rsp_type     avp_rec, end_rec;
      logic        avp_emit, end_emit;

      b = item.data_byte;
      eom = item.end_of_message;
      off = offset_ff;
      o = off + 24'd1;
      sh = {shift_ff[23:0], b};
      err = ERR_NONE;
      fin = 1'b0;
      fin_vendor = vendor_ff;
      len = sh[23:0];
      pend = 26'(off - 24'd7) + ((26'(len) + 26'd3) & ~26'd3);
      vend = flags_ff[7];
      pend_use = pend_ff;
      dlen = '0;
      next = o;
      kd = avp_kind(code_ff);
      avp_emit = 1'b0;
      end_emit = 1'b0;
      avp_rec = '0;
      end_rec = '0;
      ok = 1'b0;

      phase_in = phase_ff;
      offset_in = offset_ff;
      msglen_in = msglen_ff;
      shift_in = shift_ff;
      code_in = code_ff;
      flags_in = flags_ff;
      vendor_in = vendor_ff;
      hbh_in = hbh_ff;
      avplen_in = avplen_ff;
      pend_in = pend_ff;
      depth_in = depth_ff;
      errl_in = errl_ff;
      for (int i = 0; i < MAX_DEPTH; i++) stack_in[i] = stack_ff[i];

      // pop every group that closes at this offset
      pd = '0;
      for (int i = 0; i < MAX_DEPTH; i++) begin
         if (DW'(i) < depth_ff && stack_ff[i] != off) pd = DW'(i + 1);
      end
      scope_pop = (pd != '0) ? stack_ff[IW'(pd - 1'b1)] : msglen_ff;
      scope_cur = (depth_ff != '0) ? stack_ff[IW'(depth_ff - 1'b1)] : msglen_ff;

      if (take && errl_ff) begin
         if (eom) begin
            phase_in = PH_HDR; offset_in = '0; shift_in = '0;
            depth_in = '0; errl_in = 1'b0;
         end
      end else if (take) begin
         case (phase_ff)
            PH_HDR: begin
               shift_in = sh;
               if (off == 24'd3) msglen_in = sh[23:0];
               else if (off == 24'd4) flags_in = b;
               else if (off == 24'd7) code_in = {8'd0, sh[23:0]};
               else if (off == 24'd11) vendor_in = sh;
               else if (off == 24'd15) hbh_in = sh;
               else if (off == 24'd19) begin
                  if (msglen_ff < HEADER_BYTES || (eom && msglen_ff != HEADER_BYTES))
                     err = ERR_MISMATCH;
                  else begin
                     avp_emit = 1'b1;
                     avp_rec.kind = KIND_HEADER;
                     avp_rec.code = code_ff;
                     avp_rec.flags = flags_ff;
                     avp_rec.vendor_or_app = vendor_ff;
                     avp_rec.hop_by_hop = hbh_ff;
                     avp_rec.end_to_end = sh;
                  end
                  phase_in = PH_CODE;
               end
            end
            PH_CODE: begin
               if (off[1:0] == 2'd0) begin
                  depth_in = pd;
                  if (pd == '0 && off >= msglen_ff) err = ERR_MISMATCH;
                  else if (25'(off) + 25'd8 > 25'(scope_pop)) err = ERR_HDR_OVER;
               end
               if (err == ERR_NONE) begin
                  shift_in = sh;
                  if (off[1:0] == 2'd3) begin
                     code_in = sh;
                     phase_in = PH_LEN;
                  end
               end
            end
            PH_LEN: begin
               shift_in = sh;
               if (off[1:0] == 2'd0) flags_in = b;
               if (off[1:0] == 2'd3) begin
                  avplen_in = len;
                  if (pend > 26'(scope_cur)) err = ERR_PAD_OVER;
                  else if (len < (vend ? 24'd12 : 24'd8)) err = ERR_TOO_SMALL;
                  else begin
                     pend_in = pend[23:0];
                     pend_use = pend[23:0];
                     if (vend) phase_in = PH_VENDOR;
                     else begin
                        vendor_in = default_vendor;
                        fin_vendor = default_vendor;
                        fin = 1'b1;
                     end
                  end
               end
               dlen = len - 24'd8;
            end
            PH_VENDOR: begin
               shift_in = sh;
               if (off[1:0] == 2'd3) begin
                  vendor_in = sh;
                  fin_vendor = sh;
                  fin = 1'b1;
               end
               dlen = avplen_ff - 24'd12;
            end
            PH_SKIP: begin
               if (25'(off) + 25'd1 >= 25'(pend_ff)) phase_in = PH_CODE;
            end
            default: phase_in = PH_HDR;
         endcase

         if (fin) begin
            avp_rec.code = code_ff;
            avp_rec.flags = flags_ff;
            avp_rec.vendor_or_app = fin_vendor;
            avp_rec.data_length = dlen;
            avp_rec.data_offset = next;
            avp_rec.depth = 4'(depth_ff);
            avp_rec.kind = kd;
            if (kd == KIND_BASIC) begin
               avp_emit = 1'b1;
               phase_in = (pend_use == next) ? PH_CODE : PH_SKIP;
            end else if (depth_ff >= DW'(MAX_DEPTH)) begin
               err = ERR_TOO_DEEP;
            end else begin
               avp_emit = 1'b1;
               stack_in[IW'(depth_ff)] = next + dlen;
               depth_in = depth_ff + 1'b1;
               phase_in = PH_CODE;
            end
         end
         offset_in = o;

         end_rec.kind = KIND_ERROR;
         end_rec.data_offset = off;
         if (err != ERR_NONE) begin
            end_emit = 1'b1;
            end_rec.error_code = err;
            if (eom) begin
               phase_in = PH_HDR; offset_in = '0; shift_in = '0;
               depth_in = '0; errl_in = 1'b0;
            end else errl_in = 1'b1;
         end else if (eom) begin
            end_emit = 1'b1;
            if (phase_in == PH_HDR) end_rec.error_code = ERR_SHORT;
            else begin
               if (phase_in == PH_CODE && o[1:0] == 2'd0 && o == msglen_in) begin
                  ok = 1'b1;
                  for (int i = 0; i < MAX_DEPTH; i++) begin
                     if (DW'(i) < depth_in && stack_in[i] != o) ok = 1'b0;
                  end
               end
               if (ok) begin
                  end_rec = '0;
                  end_rec.kind = KIND_OK;
               end else end_rec.error_code = ERR_MISMATCH;
            end
            phase_in = PH_HDR; offset_in = '0; shift_in = '0;
            depth_in = '0; errl_in = 1'b0;
         end
      end

      // pack records, mark the final one of this byte
      rec0 = avp_emit ? avp_rec : end_rec;
      rec1 = end_rec;
      rec_count = 2'(avp_emit) + 2'(end_emit);
      rec0.last = (rec_count == 2'd1);
      rec1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR;
         offset_ff <= '0;
         msglen_ff <= '0;
         shift_ff  <= '0;
         code_ff   <= '0;
         flags_ff  <= '0;
         vendor_ff <= '0;
         hbh_ff    <= '0;
         avplen_ff <= '0;
         pend_ff   <= '0;
         depth_ff  <= '0;
         errl_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
         msglen_ff <= msglen_in;
         shift_ff  <= shift_in;
         code_ff   <= code_in;
         flags_ff  <= flags_in;
         vendor_ff <= vendor_in;
         hbh_ff    <= hbh_in;
         avplen_ff <= avplen_in;
         pend_ff   <= pend_in;
         depth_ff  <= depth_in;
         errl_ff   <= errl_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_DEPTH; i++) stack_ff[i] <= stack_in[i];
   end

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(MAX_DEPTH))
      else $error("group depth over limit");
   a_swallow: assert property (@(posedge clock) disable iff (reset)
      (take && errl_ff) |-> rec_count == 2'd0)
      else $error("record while swallowing");
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (take && item.end_of_message) |=> (phase_ff == PH_HDR && offset_ff == '0))
      else $error("no restart after end of message");

endmodule

// ----- hw/rtl/dasp_queue.sv -----
// ----------------------------------------------------------------------------
// dasp_queue
// Short record queue: two writes, one read per cycle.
// ----------------------------------------------------------------------------
module dasp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        push_count,
   input  dasp_pkg::rsp_type push0,
   input  dasp_pkg::rsp_type push1,
   input  logic              pop,
   output logic              nonempty,
   output logic              nearly_full,
   output dasp_pkg::rsp_type head
);
   import dasp_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);

   rsp_type       mem_ff [QUEUE_DEPTH];
   logic [AW-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [AW:0]   count_ff, count_in;

   assign nonempty    = (count_ff != '0);
   assign nearly_full = (count_ff > (AW+1)'(QUEUE_DEPTH - 2));
   assign head        = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff + AW'(push_count);
      rptr_in  = rptr_ff + AW'(pop);
      count_in = count_ff + (AW+1)'(push_count) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) mem_ff[wptr_ff] <= push0;
      if (push_count == 2'd2) mem_ff[wptr_ff + 1'b1] <= push1;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (AW+1)'(QUEUE_DEPTH))
      else $error("record queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> nonempty)
      else $error("pop from empty queue");

endmodule

// ----- hw/rtl/dasp_back.sv -----
// ----------------------------------------------------------------------------
// dasp_back
// Output register: drains the record queue onto the result channel.
// ----------------------------------------------------------------------------
module dasp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_nonempty,
   input  dasp_pkg::rsp_type q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dasp_pkg::rsp_type rsp_data
);
   import dasp_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign q_pop     = q_nonempty && (!valid_ff || !rsp_stall);
   assign valid_in  = q_pop || (valid_ff && rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (q_pop) data_ff <= q_head;
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_stall) |=> (valid_ff && $stable(data_ff)))
      else $error("stalled record changed");

endmodule
